// File: rtl/hpt_pkg.sv
// ============================================================================
// hpt_pkg
// Shared types and constants for the homogeneous point transform pipeline.
// ============================================================================
`default_nettype none

package hpt_pkg;

  // Fixed-point format and derived datapath widths.
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;
  localparam int PW         = 2 * CW;
  localparam int SUMW       = PW + 2;
  localparam int SW         = SUMW - FRAC_BITS;
  localparam int QW         = CW;
  localparam int LANES      = 3;

  // Divider pipeline shape.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QW / DIV_STEPS;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int MAT_LAT    = 2;
  localparam int TOTAL_LAT  = MAT_LAT + DIV_LAT;

  // Configuration register file.
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 2 * CW;
  localparam int CFG_IDX_W  = 4;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);

  // Configuration register indexes.
  localparam int REG_COL0_ROWS01 = 0;
  localparam int REG_COL0_ROWS23 = 1;
  localparam int REG_COL1_ROWS01 = 2;
  localparam int REG_COL1_ROWS23 = 3;
  localparam int REG_COL2_ROWS01 = 4;
  localparam int REG_COL2_ROWS23 = 5;
  localparam int REG_COL3_ROWS01 = 6;
  localparam int REG_COL3_ROWS23 = 7;

  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  localparam logic [CW-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MAX_NEG = 32'h8000_0000;

  typedef enum logic {
    OP_POINT     = 1'b0,
    OP_DIRECTION = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic signed [CW-1:0]  x_in;
    logic signed [CW-1:0]  y_in;
    logic signed [CW-1:0]  z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0]  x_out;
    logic signed [CW-1:0]  y_out;
    logic signed [CW-1:0]  z_out;
    logic                  skipped_divide;
    logic                  saturated;
  } out_item_t;

  typedef logic [CW-1:0]        coef_t;
  typedef coef_t [3:0][3:0]     mat_t;     // [column][row]
  typedef logic signed [SW-1:0] sval_t;

  // Row sums leaving the matrix stage.
  typedef struct packed {
    logic             valid;
    logic             point;
    sval_t [3:0]      s;
  } mat_res_t;

  // Request into the divider pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 skipped;
    logic                 bypass;
    sval_t [LANES-1:0]    num;
    sval_t                den;
  } div_req_t;

  // Per-item control carried along the divider.
  typedef struct packed {
    logic valid;
    logic skipped;
    logic bypass;
  } div_ctl_t;

  // Per-lane flags carried along the divider.
  typedef struct packed {
    logic           neg;
    logic           big;
    logic           bsat;
    logic [CW-1:0]  bval;
  } div_lane_t;

endpackage

`default_nettype wire

// File: rtl/hpt_mat.sv
// ============================================================================
// hpt_mat
// Two-stage 4x4 matrix by vector product: products, then row sums.
// ============================================================================
`default_nettype none

module hpt_mat (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire hpt_pkg::in_item_t in_item,
  input  wire hpt_pkg::mat_t     mat,
  output hpt_pkg::mat_res_t      res
);

  logic                              v1_r;
  logic                              point1_r;
  logic signed [hpt_pkg::PW-1:0]     prod_r   [4][3];
  logic signed [hpt_pkg::PW-1:0]     prod_nxt [4][3];
  logic signed [hpt_pkg::CW-1:0]     trans_r  [4];
  logic signed [hpt_pkg::CW-1:0]     trans_nxt[4];
  logic signed [hpt_pkg::CW-1:0]     vec      [3];
  logic                              point_in;

  logic                              v2_r;
  logic                              point2_r;
  hpt_pkg::sval_t [3:0]              s_r;
  hpt_pkg::sval_t [3:0]              s_nxt;

  // Stage one: twelve products and the translation terms.
  always_comb begin
    vec[0]   = in_item.x_in;
    vec[1]   = in_item.y_in;
    vec[2]   = in_item.z_in;
    point_in = (in_item.opcode == hpt_pkg::OP_POINT);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(mat[c][r]) * vec[c];
      end
      trans_nxt[r] = point_in ? $signed(mat[3][r]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    point1_r <= point_in;
    prod_r   <= prod_nxt;
    trans_r  <= trans_nxt;
  end

  // Stage two: exact row sums, then floor shift to the output format.
  always_comb begin
    logic signed [hpt_pkg::SUMW-1:0] sum;
    for (int r = 0; r < 4; r++) begin
      sum = hpt_pkg::SUMW'(prod_r[r][0]) + hpt_pkg::SUMW'(prod_r[r][1])
          + hpt_pkg::SUMW'(prod_r[r][2])
          + (hpt_pkg::SUMW'(trans_r[r]) <<< hpt_pkg::FRAC_BITS);
      s_nxt[r] = hpt_pkg::SW'(sum >>> hpt_pkg::FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    point2_r <= point1_r;
    s_r      <= s_nxt;
  end

  assign res.valid = v2_r;
  assign res.point = point2_r;
  assign res.s     = s_r;

endmodule

`default_nettype wire

// File: rtl/hpt_div.sv
// ============================================================================
// hpt_div
// Pipelined restoring divider for three lanes sharing one divisor,
// with saturation and a bypass path for undivided results.
// ============================================================================
`default_nettype none

module hpt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpt_pkg::div_req_t  req,
  output logic                    out_valid,
  output hpt_pkg::out_item_t      out_item
);

  localparam int SHIFT = hpt_pkg::CW - hpt_pkg::FRAC_BITS;
  localparam int CMPW  = hpt_pkg::SW + SHIFT;
  localparam int NS    = hpt_pkg::DIV_STAGES + 1;
  localparam int L     = hpt_pkg::LANES;

  hpt_pkg::div_ctl_t          ctl_r  [NS];
  hpt_pkg::div_lane_t         lane_r [NS][L];
  logic [hpt_pkg::SW-1:0]     ad_r   [NS];
  logic [hpt_pkg::SW-1:0]     rem_r  [NS][L];
  logic [hpt_pkg::CW-1:0]     low_r  [NS][L];
  logic [hpt_pkg::QW-1:0]     q_r    [NS][L];

  hpt_pkg::div_lane_t         lane_nxt [L];
  logic [hpt_pkg::SW-1:0]     ad_nxt;
  logic [hpt_pkg::SW-1:0]     rem_nxt  [L];
  logic [hpt_pkg::CW-1:0]     low_nxt  [L];

  // Prepare magnitudes, signs, the overflow precheck and the bypass value.
  always_comb begin
    logic [hpt_pkg::SW-1:0] an;
    logic                   ovf;
    hpt_pkg::sval_t         n;
    ad_nxt = req.den[hpt_pkg::SW-1] ? hpt_pkg::SW'(-req.den) : req.den;
    for (int i = 0; i < L; i++) begin
      n   = req.num[i];
      an  = n[hpt_pkg::SW-1] ? hpt_pkg::SW'(-n) : n;
      ovf = !((&n[hpt_pkg::SW-1:hpt_pkg::CW-1]) || !(|n[hpt_pkg::SW-1:hpt_pkg::CW-1]));
      lane_nxt[i].neg  = n[hpt_pkg::SW-1] ^ req.den[hpt_pkg::SW-1];
      lane_nxt[i].big  = {{SHIFT{1'b0}}, an} >= {ad_nxt, {SHIFT{1'b0}}};
      lane_nxt[i].bsat = ovf;
      lane_nxt[i].bval = ovf ? (n[hpt_pkg::SW-1] ? hpt_pkg::MAX_NEG : hpt_pkg::MAX_POS)
                             : n[hpt_pkg::CW-1:0];
      rem_nxt[i] = an >> SHIFT;
      low_nxt[i] = an[hpt_pkg::CW-1:0] << hpt_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0].skipped <= req.skipped;
    ctl_r[0].bypass  <= req.bypass;
    ad_r[0]          <= ad_nxt;
    for (int i = 0; i < L; i++) begin
      lane_r[0][i] <= lane_nxt[i];
      rem_r[0][i]  <= rem_nxt[i];
      low_r[0][i]  <= low_nxt[i];
      q_r[0][i]    <= '0;
    end
  end

  // Quotient stages: DIV_STEPS restoring steps per register stage.
  for (genvar k = 0; k < hpt_pkg::DIV_STAGES; k++) begin : g_stage
    logic [hpt_pkg::SW-1:0] rem_s [L];
    logic [hpt_pkg::CW-1:0] low_s [L];
    logic [hpt_pkg::QW-1:0] q_s   [L];

    always_comb begin
      logic [hpt_pkg::SW:0] t;
      logic                 ge;
      for (int i = 0; i < L; i++) begin
        rem_s[i] = rem_r[k][i];
        low_s[i] = low_r[k][i];
        q_s[i]   = q_r[k][i];
        for (int j = 0; j < hpt_pkg::DIV_STEPS; j++) begin
          t        = {rem_s[i], low_s[i][hpt_pkg::CW-1]};
          ge       = t >= {1'b0, ad_r[k]};
          rem_s[i] = ge ? hpt_pkg::SW'(t - {1'b0, ad_r[k]}) : hpt_pkg::SW'(t);
          low_s[i] = low_s[i] << 1;
          q_s[i]   = {q_s[i][hpt_pkg::QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1].valid <= 1'b0;
      end else begin
        ctl_r[k+1].valid <= ctl_r[k].valid;
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[k+1].skipped <= ctl_r[k].skipped;
      ctl_r[k+1].bypass  <= ctl_r[k].bypass;
      ad_r[k+1]          <= ad_r[k];
      for (int i = 0; i < L; i++) begin
        lane_r[k+1][i] <= lane_r[k][i];
        rem_r[k+1][i]  <= rem_s[i];
        low_r[k+1][i]  <= low_s[i];
        q_r[k+1][i]    <= q_s[i];
      end
    end
  end

  // Final sign, saturation and result selection.
  logic [hpt_pkg::CW-1:0] val_nxt [L];
  logic                   sat_nxt [L];
  hpt_pkg::out_item_t     item_nxt;
  hpt_pkg::out_item_t     item_r;
  logic                   valid_r;

  always_comb begin
    hpt_pkg::div_lane_t     ln;
    logic [hpt_pkg::QW-1:0] q;
    for (int i = 0; i < L; i++) begin
      ln = lane_r[NS-1][i];
      q  = q_r[NS-1][i];
      if (ctl_r[NS-1].bypass) begin
        val_nxt[i] = ln.bval;
        sat_nxt[i] = ln.bsat;
      end else if (ln.big) begin
        val_nxt[i] = ln.neg ? hpt_pkg::MAX_NEG : hpt_pkg::MAX_POS;
        sat_nxt[i] = 1'b1;
      end else if (ln.neg) begin
        sat_nxt[i] = q > hpt_pkg::MAX_NEG;
        val_nxt[i] = sat_nxt[i] ? hpt_pkg::MAX_NEG : hpt_pkg::CW'(-q);
      end else begin
        sat_nxt[i] = q > hpt_pkg::MAX_POS;
        val_nxt[i] = sat_nxt[i] ? hpt_pkg::MAX_POS : q;
      end
    end
    item_nxt.x_out          = val_nxt[0];
    item_nxt.y_out          = val_nxt[1];
    item_nxt.z_out          = val_nxt[2];
    item_nxt.skipped_divide = ctl_r[NS-1].skipped;
    item_nxt.saturated      = sat_nxt[0] | sat_nxt[1] | sat_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_r[NS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

// File: rtl/homogeneous_point_transform.sv
// ============================================================================
// homogeneous_point_transform
// 4x4 homogeneous transform of Q16.16 vectors with perspective divide.
// ============================================================================
// Pipeline: from the start transfer to the out_valid strobe, an item passes
//   2 matrix stages, 1 divider setup stage, 16 quotient stages and 1 output stage.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// The quotient stages, two restoring steps each, set the pipeline depth.
// Reset: synchronous, active low; clears all valid bits and loads the
//   identity matrix into the configuration registers.
`default_nettype none

module homogeneous_point_transform (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire hpt_pkg::in_item_t             in_item,
  output logic                               out_valid,
  output hpt_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hpt_pkg::REG_W-1:0]     cfg_data
);

  logic [hpt_pkg::REG_W-1:0] cfg_r [hpt_pkg::NUM_REGS];
  hpt_pkg::mat_t             mat;
  hpt_pkg::mat_res_t         mres;
  hpt_pkg::div_req_t         dreq;
  logic                      w_zero;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration register file; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= hpt_pkg::CFG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready
                 && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS))) begin
      cfg_r[cfg_index[hpt_pkg::REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Unpack the column-major matrix, two entries per register.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if ((r & 1) != 0) begin
          mat[c][r] = cfg_r[c * 2 + (r >> 1)][hpt_pkg::REG_W-1:hpt_pkg::CW];
        end else begin
          mat[c][r] = cfg_r[c * 2 + (r >> 1)][hpt_pkg::CW-1:0];
        end
      end
    end
  end

  hpt_mat u_mat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_item  (in_item),
    .mat      (mat),
    .res      (mres)
  );

  // A zero w in point mode skips the divide; direction mode never divides.
  always_comb begin
    w_zero       = (mres.s[3] == '0);
    dreq.valid   = mres.valid;
    dreq.skipped = mres.point && w_zero;
    dreq.bypass  = !mres.point || w_zero;
    dreq.den     = mres.s[3];
    for (int i = 0; i < hpt_pkg::LANES; i++) begin
      dreq.num[i] = mres.s[i];
    end
  end

  hpt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (dreq),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Every result strobe traces back to a start transfer at the full pipeline depth.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, hpt_pkg::TOTAL_LAT))
    else $error("result strobe without matching start transfer");

  // A skipped divide only happens for an item sent in point mode.
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.skipped_divide
      |-> $past(in_item.opcode == hpt_pkg::OP_POINT, hpt_pkg::TOTAL_LAT))
    else $error("skipped divide flagged for a direction item");

  // The saturation flag implies at least one coordinate at a range limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      (out_item.x_out == hpt_pkg::MAX_POS || out_item.x_out == hpt_pkg::MAX_NEG ||
       out_item.y_out == hpt_pkg::MAX_POS || out_item.y_out == hpt_pkg::MAX_NEG ||
       out_item.z_out == hpt_pkg::MAX_POS || out_item.z_out == hpt_pkg::MAX_NEG))
    else $error("saturated flag without a clamped coordinate");

endmodule

`default_nettype wire
